// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL. Defining NO_ASSERTIONS
// compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks an implication at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks a plain condition at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, cond, msg)
`endif

`endif

// ===== hw/rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation step package
// Widths, the row width mask and the B3/S23 next-generation function.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int RowW      = 64;
  localparam int WidthW    = 7;
  localparam int MAX_WIDTH = 64;
  localparam int HeldW     = 2;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(MAX_WIDTH);

  typedef logic [RowW-1:0] row_t;

  // Mask of the valid cells: bit i is set when i is below the width, which
  // saturates at the largest supported width.
  function automatic row_t width_mask(input logic [WidthW-1:0] width);
    logic [WidthW-1:0] w;
    row_t              m;
    w = (width > WidthW'(MAX_WIDTH)) ? WidthW'(MAX_WIDTH) : width;
    for (int i = 0; i < RowW; i++) begin
      m[i] = (WidthW'(i) < w);
    end
    return m;
  endfunction

  // One generation of the middle row. Each cell sums its eight neighbours
  // independently; cells past either edge of the word count as dead.
  function automatic row_t next_gen(input row_t above, input row_t here,
                                    input row_t below);
    logic [RowW+1:0] pa;
    logic [RowW+1:0] ph;
    logic [RowW+1:0] pb;
    logic [3:0]      n;
    row_t            res;
    pa = {1'b0, above, 1'b0};
    ph = {1'b0, here, 1'b0};
    pb = {1'b0, below, 1'b0};
    for (int i = 0; i < RowW; i++) begin
      n = 4'(pa[i]) + 4'(pa[i+1]) + 4'(pa[i+2])
        + 4'(pb[i]) + 4'(pb[i+1]) + 4'(pb[i+2])
        + 4'(ph[i]) + 4'(ph[i+2]);
      res[i] = (n == 4'd3) || ((n == 4'd2) && here[i]);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/life_generation_step_unit.sv =====
// ----------------------------------------------------------------------------
// Life generation step unit
// One generation of Conway's Life (birth on three, survival on two or three)
// over a grid streamed one row word per request, top row first.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  -------------------------------
//  input     in         in_valid/in_stall   row_cells, first_row, last_row
//  output    out        out_valid/out_stall next_row_cells, grid_done
//  config    in         cfg_valid/cfg_ready cfg_data (grid width)
//
//  A request with at most one result does not hold the input, so rows stream
//  at one per clock while the output does not stall. A bottom row of a grid
//  with at least two rows yields two results and holds the input while the first
//  moves, as the single output register takes one result per cycle.
//  Reset is synchronous and restores a width of 64 and an empty row store.
//  A stall on the output backs up through the job register into in_stall;
//  one request is still taken while a finished result waits to be taken.
//
module life_generation_step_unit
  import lgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RowW-1:0]   row_cells,
  input  logic              first_row,
  input  logic              last_row,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [RowW-1:0]   next_row_cells,
  output logic              grid_done,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WidthW-1:0] cfg_data
);

  // Configuration register. Writes are taken in any cycle.
  logic [WidthW-1:0] grid_width;

  // Row store: the two most recent rows of the grid being streamed.
  row_t             upper_row;
  row_t             middle_row;
  logic [HeldW-1:0] rows_held;

  // Job register: the three rows around the next row to compute, and which
  // of the two possible results of the request are still owed. After the
  // first result goes out the rows shift up by one, with a dead row entering
  // at the bottom, so the flush result uses the same next-generation logic.
  row_t job_above;
  row_t job_mid;
  row_t job_below;
  logic job_need_a;
  logic job_need_b;

  row_t out_cells;
  logic out_done;
  logic out_full;

  logic             accept;
  logic             job_valid;
  logic             out_load;
  logic             job_last;
  row_t             mask;
  row_t             row_in;
  row_t             gen_row;
  logic [HeldW-1:0] held0;
  row_t             upper0;
  row_t             middle0;
  logic             has_a;
  row_t             upper_row_next;
  row_t             middle_row_next;
  logic [HeldW-1:0] rows_held_next;
  row_t             load_above;
  row_t             load_mid;
  row_t             load_below;

  assign cfg_ready = 1'b1;

  assign mask      = width_mask(grid_width);
  assign row_in    = row_cells & mask;
  assign job_valid = job_need_a | job_need_b;

  // The output register takes a result when it is empty or being emptied.
  assign out_load = job_valid && (!out_full || !out_stall);
  // The job empties this cycle when exactly one result is left and it moves.
  assign job_last = out_load && (job_need_a ^ job_need_b);
  assign in_stall = job_valid && !job_last;
  assign accept   = in_valid && !in_stall;

  assign gen_row = next_gen(job_above, job_mid, job_below) & mask;

  // Row store update and job set-up for an accepted request. A top row
  // throws away whatever an unfinished grid left behind.
  always_comb begin
    held0   = first_row ? '0 : rows_held;
    upper0  = first_row ? '0 : upper_row;
    middle0 = first_row ? '0 : middle_row;
    has_a   = (held0 != '0);

    if (has_a) begin
      load_above      = (held0 >= HeldW'(2)) ? upper0 : '0;
      load_mid        = middle0;
      load_below      = row_in;
      upper_row_next  = middle0;
      middle_row_next = row_in;
      rows_held_next  = HeldW'(2);
    end else begin
      // First row of a grid: nothing to emit unless it is also the last.
      load_above      = '0;
      load_mid        = row_in;
      load_below      = '0;
      upper_row_next  = '0;
      middle_row_next = row_in;
      rows_held_next  = HeldW'(1);
    end

    if (last_row) begin
      upper_row_next  = '0;
      middle_row_next = '0;
      rows_held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= WidthReset;
    end else if (cfg_valid && cfg_ready) begin
      grid_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_held  <= '0;
    end else if (accept) begin
      upper_row  <= upper_row_next;
      middle_row <= middle_row_next;
      rows_held  <= rows_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_need_a <= 1'b0;
      job_need_b <= 1'b0;
    end else if (accept) begin
      job_need_a <= has_a;
      job_need_b <= last_row;
    end else if (out_load) begin
      if (job_need_a) begin
        job_need_a <= 1'b0;
      end else begin
        job_need_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_above <= load_above;
      job_mid   <= load_mid;
      job_below <= load_below;
    end else if (out_load && job_need_a) begin
      job_above <= job_mid;
      job_mid   <= job_below;
      job_below <= '0;
    end
  end

  // Output register. The first of two results of a request never ends the
  // grid; the flush result always does.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cells <= gen_row;
      out_done  <= !job_need_a;
    end
  end

  assign out_valid      = out_full;
  assign next_row_cells = out_cells;
  assign grid_done      = out_done;

`include "assert_macros.svh"

  `ASSERT_CLK(a_idle_takes_request, !job_valid |-> !in_stall,
              "request refused while no job was pending")
  `ASSERT_CLK(a_last_row_clears, (accept && last_row) |=> (rows_held == '0),
              "row store not cleared after the bottom row")
  `ASSERT_CLK(a_held_range, rows_held != 2'd3, "row count out of range")
  `ASSERT_CLK(a_width_zero, out_full |-> ((out_cells & ~mask) == '0),
              "live cell reported beyond the grid width")

endmodule
